### design/prot_pkg.sv
// ----------------------------------------------------------------------------
// prot_pkg
// Shared types, constants and table helpers for the pivot rotation block.
// ----------------------------------------------------------------------------
package prot_pkg;

   // default angle resolution and queue size
   localparam int ANGLE_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   // field and datapath widths
   localparam int COORD_W    = 32;
   localparam int COLOR_W    = 8;
   localparam int DATA_W     = 3 * COORD_W + 3 * COLOR_W;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W     = 13;
   localparam int MAG_W      = 15;
   localparam int TRIG_W     = MAG_W + 1;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + TRIG_W;
   localparam int FRAC_SHIFT = 15;
   localparam int SHR_W      = PROD_W - FRAC_SHIFT;
   localparam int RES_W      = SHR_W + 1;

   // register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PIVOT_X    = 2'd0,
      CSR_PIVOT_Y    = 2'd1,
      CSR_PIVOT_Z    = 2'd2,
      CSR_ANGLE_STEP = 2'd3
   } csr_index_type;

   // pass-through part of a point
   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               last;
   } point_tail_type;

   // one request as handed from the front end to the arithmetic back end
   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_q;
      logic signed [TRIG_W-1:0] cos_q;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dz;
      point_tail_type           tail;
   } rot_item_type;

   // table construction constants, Q62 fixed point
   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
   localparam int SERIES_TERMS = 16;

   // (2n)(2n+1) divisors of the sine series
   localparam logic [63:0] SERIES_DIV [1:SERIES_TERMS] = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
   };

   // Q62 product, keeping bits 125 down to 62
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[125:62];
   endfunction

   // round(32767 * sin(x)) for a Q62 angle in radians, elaboration time only
   function automatic logic [MAG_W-1:0] sine_from_angle(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = mul_q62(term, x2) / SERIES_DIV[n];
         if (n[0]) begin
            sum = (term > sum) ? 64'd0 : sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q62) begin
         sum = ONE_Q62;
      end
      v = ((sum >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[MAG_W-1:0];
   endfunction

endpackage

### design/prot_sine_rom.sv
// ----------------------------------------------------------------------------
// prot_sine_rom
// Quarter-wave sine table with two registered read ports (sine and cosine).
// ----------------------------------------------------------------------------
module prot_sine_rom
   import prot_pkg::*;
#(
   parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF
) (
   input  logic                                            clock,
   input  logic                                            rd_en,
   input  logic [$clog2(90*ANGLE_STEPS_PER_DEGREE+1)-1:0]  s_addr,
   input  logic [$clog2(90*ANGLE_STEPS_PER_DEGREE+1)-1:0]  c_addr,
   output logic [MAG_W-1:0]                                s_mag,
   output logic [MAG_W-1:0]                                c_mag
);

   localparam int QUARTER = 90 * ANGLE_STEPS_PER_DEGREE;
   localparam logic [63:0] ANGLE_DIV = 64'(180 * ANGLE_STEPS_PER_DEGREE);
   localparam logic [63:0] PI_QUOT   = PI_Q62 / ANGLE_DIV;
   localparam logic [63:0] PI_REM    = PI_Q62 % ANGLE_DIV;

   logic [MAG_W-1:0] rom_tab [0:QUARTER];
   logic [MAG_W-1:0] s_mag_ff;
   logic [MAG_W-1:0] c_mag_ff;

   // table contents, one entry per angle step of the first quadrant
   for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
      localparam logic [63:0] ANGLE_K = 64'(k) * PI_QUOT + (64'(k) * PI_REM) / ANGLE_DIV;
      localparam logic [MAG_W-1:0] SINE_K = sine_from_angle(ANGLE_K);
      assign rom_tab[k] = SINE_K;
   end

   // registered lookups, held while the front end stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s_mag_ff <= rom_tab[s_addr];
         c_mag_ff <= rom_tab[c_addr];
      end
   end

   assign s_mag = s_mag_ff;
   assign c_mag = c_mag_ff;

endmodule

### design/prot_front.sv
// ----------------------------------------------------------------------------
// prot_front
// Accepts points, folds the current angle into a quadrant, looks up sine and
// cosine, forms the offsets from the pivot and advances the angle per cloud.
// ----------------------------------------------------------------------------
module prot_front
   import prot_pkg::*;
#(
   parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [DATA_W-1:0]                              req_tdata,
   input  logic                                           req_tlast,
   input  logic signed [COORD_W-1:0]                      pivot_x,
   input  logic signed [COORD_W-1:0]                      pivot_z,
   input  logic [$clog2(360*ANGLE_STEPS_PER_DEGREE)-1:0]  angle_step,
   output logic                                           push,
   output rot_item_type                                   push_item,
   input  logic                                           full
);

   localparam int QUARTER = 90 * ANGLE_STEPS_PER_DEGREE;
   localparam int FULL_STEPS = 4 * QUARTER;
   localparam int ANGLE_W = $clog2(FULL_STEPS);
   localparam int IDX_W = $clog2(QUARTER + 1);
   localparam logic [ANGLE_W-1:0] Q1 = ANGLE_W'(QUARTER);
   localparam logic [ANGLE_W-1:0] Q2 = ANGLE_W'(2 * QUARTER);
   localparam logic [ANGLE_W-1:0] Q3 = ANGLE_W'(3 * QUARTER);
   localparam logic [ANGLE_W-1:0] Q4 = ANGLE_W'(4 * QUARTER);

   logic [ANGLE_W-1:0]       angle_ff;
   logic [ANGLE_W-1:0]       angle_in;
   logic [ANGLE_W:0]         angle_sum;
   logic                     valid_ff;
   logic                     sneg_ff;
   logic                     cneg_ff;
   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dz_ff;
   point_tail_type           tail_ff;
   logic                     accept;
   logic                     advance;
   logic [ANGLE_W-1:0]       s_full;
   logic [ANGLE_W-1:0]       c_full;
   logic                     s_neg;
   logic                     c_neg;
   logic [IDX_W-1:0]         s_addr;
   logic [IDX_W-1:0]         c_addr;
   logic [MAG_W-1:0]         s_mag;
   logic [MAG_W-1:0]         c_mag;
   logic [TRIG_W-1:0]        s_ext;
   logic [TRIG_W-1:0]        c_ext;
   logic signed [COORD_W-1:0] x_w;
   logic signed [COORD_W-1:0] z_w;

   // the stage moves on whenever the queue can take its contents
   assign advance    = !valid_ff || !full;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;
   assign push       = valid_ff && !full;

   // quadrant folding of the current angle
   always_comb begin
      priority if (angle_ff <= Q1) begin
         s_full = angle_ff;
         c_full = Q1 - angle_ff;
         s_neg  = 1'b0;
         c_neg  = 1'b0;
      end else if (angle_ff <= Q2) begin
         s_full = Q2 - angle_ff;
         c_full = angle_ff - Q1;
         s_neg  = 1'b0;
         c_neg  = 1'b1;
      end else if (angle_ff <= Q3) begin
         s_full = angle_ff - Q2;
         c_full = Q3 - angle_ff;
         s_neg  = 1'b1;
         c_neg  = 1'b1;
      end else begin
         s_full = Q4 - angle_ff;
         c_full = angle_ff - Q3;
         s_neg  = 1'b1;
         c_neg  = 1'b0;
      end
   end

   assign s_addr = s_full[IDX_W-1:0];
   assign c_addr = c_full[IDX_W-1:0];

   prot_sine_rom #(
      .ANGLE_STEPS_PER_DEGREE(ANGLE_STEPS_PER_DEGREE)
   ) u_sine_rom (
      .clock  (clock),
      .rd_en  (accept),
      .s_addr (s_addr),
      .c_addr (c_addr),
      .s_mag  (s_mag),
      .c_mag  (c_mag)
   );

   // angle advance after the last point of a cloud, wrapped to one turn
   assign angle_sum = {1'b0, angle_ff} + {1'b0, angle_step};
   always_comb begin
      angle_in = angle_ff;
      if (accept && req_tlast) begin
         if (angle_sum >= (ANGLE_W + 1)'(FULL_STEPS)) begin
            angle_in = angle_sum[ANGLE_W-1:0] - Q4;
         end else begin
            angle_in = angle_sum[ANGLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         angle_ff <= angle_in;
         if (advance) begin
            valid_ff <= req_tvalid;
         end
      end
   end

   // offsets from the pivot and pass-through fields
   assign x_w = req_tdata[COORD_W-1:0];
   assign z_w = req_tdata[3*COORD_W-1:2*COORD_W];

   always_ff @(posedge clock) begin
      if (accept) begin
         sneg_ff       <= s_neg;
         cneg_ff       <= c_neg;
         dx_ff         <= DIFF_W'(x_w) - DIFF_W'(pivot_x);
         dz_ff         <= DIFF_W'(z_w) - DIFF_W'(pivot_z);
         tail_ff.y     <= req_tdata[2*COORD_W-1:COORD_W];
         tail_ff.red   <= req_tdata[3*COORD_W+COLOR_W-1:3*COORD_W];
         tail_ff.green <= req_tdata[3*COORD_W+2*COLOR_W-1:3*COORD_W+COLOR_W];
         tail_ff.blue  <= req_tdata[3*COORD_W+3*COLOR_W-1:3*COORD_W+2*COLOR_W];
         tail_ff.last  <= req_tlast;
      end
   end

   // signed sine and cosine for the queue
   assign s_ext = {1'b0, s_mag};
   assign c_ext = {1'b0, c_mag};

   always_comb begin
      push_item.sin_q = sneg_ff ? (TRIG_W'(0) - s_ext) : s_ext;
      push_item.cos_q = cneg_ff ? (TRIG_W'(0) - c_ext) : c_ext;
      push_item.dx    = dx_ff;
      push_item.dz    = dz_ff;
      push_item.tail  = tail_ff;
   end

endmodule

### design/prot_queue.sv
// ----------------------------------------------------------------------------
// prot_queue
// Small first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module prot_queue
   import prot_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rot_item_type push_item,
   output logic         full,
   input  logic         pop,
   output rot_item_type head_item,
   output logic         empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rot_item_type     items_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = items_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### design/prot_back.sv
// ----------------------------------------------------------------------------
// prot_back
// Rotation arithmetic: four products, sums with floor shift, pivot add and
// saturation, ending in the response register.
// ----------------------------------------------------------------------------
module prot_back
   import prot_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [COORD_W-1:0] pivot_x,
   input  logic signed [COORD_W-1:0] pivot_z,
   output logic                      pop,
   input  rot_item_type              head_item,
   input  logic                      empty,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [DATA_W-1:0]         rsp_tdata,
   output logic                      rsp_tlast
);

   logic                      advance;
   logic                      v1_ff;
   logic                      v2_ff;
   logic                      v3_ff;
   logic signed [PROD_W-1:0]  dx_w;
   logic signed [PROD_W-1:0]  dz_w;
   logic signed [PROD_W-1:0]  sin_w;
   logic signed [PROD_W-1:0]  cos_w;
   logic signed [PROD_W-1:0]  p_xc_ff;
   logic signed [PROD_W-1:0]  p_zs_ff;
   logic signed [PROD_W-1:0]  p_xs_ff;
   logic signed [PROD_W-1:0]  p_zc_ff;
   logic signed [PROD_W-1:0]  x_acc;
   logic signed [PROD_W-1:0]  z_acc;
   logic signed [SHR_W-1:0]   x_shr_ff;
   logic signed [SHR_W-1:0]   z_shr_ff;
   logic signed [RES_W-1:0]   x_res;
   logic signed [RES_W-1:0]   z_res;
   logic [COORD_W-1:0]        x_out_ff;
   logic [COORD_W-1:0]        z_out_ff;
   point_tail_type            tail1_ff;
   point_tail_type            tail2_ff;
   point_tail_type            tail3_ff;

   // clamp to the signed 32-bit range
   function automatic logic [COORD_W-1:0] sat_coord(input logic [RES_W-1:0] v);
      if (!v[RES_W-1] && (v[RES_W-2:COORD_W-1] != '0)) begin
         return {1'b0, {(COORD_W - 1){1'b1}}};
      end else if (v[RES_W-1] && (v[RES_W-2:COORD_W-1] != '1)) begin
         return {1'b1, {(COORD_W - 1){1'b0}}};
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

   // whole pipe moves when the response register is free
   assign advance = !v3_ff || rsp_tready;
   assign pop     = advance && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 1: products
   assign dx_w  = PROD_W'(head_item.dx);
   assign dz_w  = PROD_W'(head_item.dz);
   assign sin_w = PROD_W'(head_item.sin_q);
   assign cos_w = PROD_W'(head_item.cos_q);

   always_ff @(posedge clock) begin
      if (advance) begin
         p_xc_ff  <= dx_w * cos_w;
         p_zs_ff  <= dz_w * sin_w;
         p_xs_ff  <= dx_w * sin_w;
         p_zc_ff  <= dz_w * cos_w;
         tail1_ff <= head_item.tail;
      end
   end

   // stage 2: sums and floor shift by the Q1.15 scale
   assign x_acc = p_xc_ff - p_zs_ff;
   assign z_acc = p_xs_ff + p_zc_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_shr_ff <= x_acc[PROD_W-1:FRAC_SHIFT];
         z_shr_ff <= z_acc[PROD_W-1:FRAC_SHIFT];
         tail2_ff <= tail1_ff;
      end
   end

   // stage 3: back to absolute position with saturation
   assign x_res = RES_W'(x_shr_ff) + RES_W'(pivot_x);
   assign z_res = RES_W'(z_shr_ff) + RES_W'(pivot_z);

   always_ff @(posedge clock) begin
      if (advance) begin
         x_out_ff <= sat_coord(x_res);
         z_out_ff <= sat_coord(z_res);
         tail3_ff <= tail2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tlast  = tail3_ff.last;
   assign rsp_tdata  = {tail3_ff.blue, tail3_ff.green, tail3_ff.red,
                        z_out_ff, tail3_ff.y, x_out_ff};

endmodule

### design/point_rotate_about_y_pivot.sv
// Throughput: one point per cycle while the response side does not stall; each stage
// handles one point a cycle and the sine table gives one sine and one cosine lookup per
// cycle through its two read ports.
// Stalls on the response side fill the request queue before req_tready drops.
// Reset (synchronous, active high) clears the angle to zero, the pivot and step
// registers to zero, and empties the queue and every pipeline stage.
// ----------------------------------------------------------------------------
// point_rotate_about_y_pivot
// Rotates a stream of coloured points about a vertical axis through a pivot,
// with the angle advancing by a programmable step after each cloud.
// ----------------------------------------------------------------------------
module point_rotate_about_y_pivot
   import prot_pkg::*;
#(
   parameter int ANGLE_STEPS_PER_DEGREE = ANGLE_STEPS_DEF,
   parameter int QUEUE_DEPTH            = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // x_in, y_in, z_in, red_in, green_in, blue_in
   input  logic                  req_tlast,   // last_of_cloud
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [DATA_W-1:0]     rsp_tdata,   // x_out, y_out, z_out, red_out, green_out, blue_out
   output logic                  rsp_tlast,   // cloud_end
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FULL_STEPS = 360 * ANGLE_STEPS_PER_DEGREE;
   localparam int ANGLE_W = $clog2(FULL_STEPS);

   logic signed [COORD_W-1:0] pivot_x_ff;
   logic signed [COORD_W-1:0] pivot_z_ff;
   logic [ANGLE_W-1:0]        step_ff;
   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_empty;
   rot_item_type              q_in_item;
   rot_item_type              q_head_item;

   // step reduced below one full turn by conditional subtraction
   function automatic logic [ANGLE_W-1:0] reduce_step(input logic [STEP_W-1:0] v);
      logic [STEP_W-1:0] red;
      red = v;
      for (int j = 4; j >= 0; j--) begin
         if (32'(red) >= 32'(FULL_STEPS << j)) begin
            red = red - STEP_W'(FULL_STEPS << j);
         end
      end
      return ANGLE_W'(red);
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_x_ff <= '0;
         pivot_z_ff <= '0;
         step_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PIVOT_X: begin
               pivot_x_ff <= csr_wdata;
            end
            CSR_PIVOT_Y: begin
               // cancels out of a rotation about y, nothing to keep
            end
            CSR_PIVOT_Z: begin
               pivot_z_ff <= csr_wdata;
            end
            CSR_ANGLE_STEP: begin
               step_ff <= reduce_step(csr_wdata[STEP_W-1:0]);
            end
         endcase
      end
   end

   prot_front #(
      .ANGLE_STEPS_PER_DEGREE(ANGLE_STEPS_PER_DEGREE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .pivot_x    (pivot_x_ff),
      .pivot_z    (pivot_z_ff),
      .angle_step (step_ff),
      .push       (q_push),
      .push_item  (q_in_item),
      .full       (q_full)
   );

   prot_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head_item (q_head_item),
      .empty     (q_empty)
   );

   prot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pivot_x    (pivot_x_ff),
      .pivot_z    (pivot_z_ff),
      .pop        (q_pop),
      .head_item  (q_head_item),
      .empty      (q_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // queue never overrun by the front end
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("request pushed into a full queue");

   // back end never drains an empty queue
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("request popped from an empty queue");

   // request side only stalls on a full queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_full)
      else $error("request channel stalled while the queue had room");

endmodule

### dv/tb_point_rotate_about_y_pivot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_rotate_about_y_pivot
// Self-checking bench for the pivot rotation block. A short table of edge
// points runs first, then random point clouds under changing pivots and
// angle steps. Each response is checked against an in-bench rotation model,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_point_rotate_about_y_pivot;
   import prot_pkg::*;

   localparam int STEPS_PER_DEG = 16;
   localparam int QUARTER       = 90 * STEPS_PER_DEG;
   localparam int FULL_TURN     = 4 * QUARTER;
   localparam int STALL_LIMIT   = 1000;
   localparam int RANDOM_POINTS = 1850;
   localparam int RANDOM_PHASES = 6;
   localparam int NUM_DIRECTED  = 19;
   localparam int NUM_SETS      = 5;
   localparam int MAX_REPORTS   = 10;

   localparam logic [63:0] PI_FIX    = 64'hC90FDAA22168C235;
   localparam logic [63:0] UNIT_FIX  = 64'h4000000000000000;
   localparam logic [63:0] HALF_TURN = 64'd2880;

   // one point as it travels through the block
   typedef struct packed {
      logic        last;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } cloud_point_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [12:0] step;
   } pivot_cfg_type;

   typedef struct packed {
      logic [2:0]      cfg_set;
      cloud_point_type pt;
      logic            fixed;
      logic [31:0]     want_x;
      logic [31:0]     want_z;
   } directed_row_type;

   // register settings of the directed part: reset values, then extremes,
   // a step beyond a turn, a step of exactly one turn and the largest step below a turn
   pivot_cfg_type cfg_table [NUM_SETS] = '{
      '{32'h00000000, 32'h00000000, 32'h00000000, 13'd0},
      '{32'h7FFFFFFF, 32'h12345678, 32'h80000000, 13'd1440},
      '{32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 13'd8191},
      '{32'h00010000, 32'h00000000, 32'hFFFF0000, 13'd5760},
      '{32'h00000000, 32'h80000000, 32'h00000000, 13'd5759}
   };

   // directed points; rows at zero angle and zero pivot carry their result
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{3'd0, '{1'b0, 8'h00, 8'h00, 8'h00, 32'h00000000, 32'h00000000, 32'h00000000},
        1'b1, 32'h00000000, 32'h00000000},
      '{3'd0, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
        1'b1, 32'h7FFEFFFF, 32'h7FFEFFFF},
      '{3'd0, '{1'b0, 8'hAA, 8'h55, 8'h00, 32'h80000000, 32'h7FFFFFFF, 32'h80000000},
        1'b1, 32'h80010000, 32'h80010000},
      '{3'd0, '{1'b1, 8'h0F, 8'hF0, 8'h3C, 32'hFFFF8000, 32'h00010000, 32'h00008000},
        1'b1, 32'h00007FFF, 32'hFFFF8001},
      '{3'd0, '{1'b1, 8'h81, 8'h42, 8'h24, 32'h00000001, 32'hFFFFFFFF, 32'hFFFFFFFF},
        1'b1, 32'hFFFFFFFF, 32'h00000000},
      '{3'd1, '{1'b1, 8'h01, 8'h02, 8'h03, 32'h7FFFFFFF, 32'h00000000, 32'h80000000},
        1'b0, 32'h0, 32'h0},
      '{3'd1, '{1'b1, 8'h10, 8'h20, 8'h30, 32'h7FFFFFFF, 32'h55555555, 32'h80000000},
        1'b0, 32'h0, 32'h0},
      '{3'd1, '{1'b1, 8'hFE, 8'hFD, 8'hFC, 32'h7FFFFFFF, 32'hAAAAAAAA, 32'h80000000},
        1'b0, 32'h0, 32'h0},
      '{3'd1, '{1'b1, 8'h7F, 8'h80, 8'h01, 32'h80000000, 32'h00000001, 32'h7FFFFFFF},
        1'b0, 32'h0, 32'h0},
      '{3'd1, '{1'b0, 8'h00, 8'hFF, 8'h00, 32'h00000000, 32'h00000000, 32'h00000000},
        1'b0, 32'h0, 32'h0},
      '{3'd2, '{1'b1, 8'h11, 8'h22, 8'h33, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF},
        1'b0, 32'h0, 32'h0},
      '{3'd2, '{1'b1, 8'h44, 8'h55, 8'h66, 32'h80000000, 32'h80000000, 32'h7FFFFFFF},
        1'b0, 32'h0, 32'h0},
      '{3'd2, '{1'b1, 8'h77, 8'h88, 8'h99, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'h12345678},
        1'b0, 32'h0, 32'h0},
      '{3'd2, '{1'b1, 8'hCC, 8'hDD, 8'hEE, 32'h00000000, 32'hF0F0F0F0, 32'h00000000},
        1'b0, 32'h0, 32'h0},
      '{3'd3, '{1'b1, 8'h5A, 8'hA5, 8'hC3, 32'hFFFE8000, 32'h00018000, 32'h00018000},
        1'b0, 32'h0, 32'h0},
      '{3'd3, '{1'b1, 8'h3C, 8'hC3, 8'h5A, 32'hFFFE8000, 32'hFFFE8000, 32'h00018000},
        1'b0, 32'h0, 32'h0},
      '{3'd4, '{1'b1, 8'hFF, 8'h00, 8'hFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
        1'b0, 32'h0, 32'h0},
      '{3'd4, '{1'b1, 8'h00, 8'hFF, 8'h00, 32'h80000000, 32'h80000000, 32'h80000000},
        1'b0, 32'h0, 32'h0},
      '{3'd4, '{1'b0, 8'h96, 8'h69, 8'h18, 32'hFFFFEDCC, 32'h00001234, 32'h00001234},
        1'b0, 32'h0, 32'h0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;   // x_in, y_in, z_in, red_in, green_in, blue_in
   logic                  req_tlast;   // last_of_cloud
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;   // x_out, y_out, z_out, red_out, green_out, blue_out
   logic                  rsp_tlast;   // cloud_end
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // hand-typed result travelling alongside a directed request
   logic        row_fixed;
   logic [31:0] row_fixed_x;
   logic [31:0] row_fixed_z;

   // bench copy of the block state and registers
   logic [14:0]  sine_lut [0:QUARTER];
   int unsigned  turn_angle;
   logic [31:0]  pivot_x_cfg;
   logic [31:0]  pivot_y_cfg;
   logic [31:0]  pivot_z_cfg;
   logic [12:0]  angle_step_cfg;

   cloud_point_type rotated_q [$];
   int              fail_count;
   int              points_done;
   int              clouds_done;
   int              phases;
   int              idle_cycles;
   bit              calm;

   point_rotate_about_y_pivot dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fixed-point product of two Q62 values
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   // round(32767 * sin) of table step k, Taylor series in Q62
   function automatic logic [14:0] quarter_sine(input int unsigned k);
      logic [63:0] step_q;
      logic [63:0] step_r;
      logic [63:0] rad;
      logic [63:0] rad_sq;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] mag;
      step_q = PI_FIX / HALF_TURN;
      step_r = PI_FIX % HALF_TURN;
      rad    = 64'(k) * step_q + (64'(k) * step_r) / HALF_TURN;
      rad_sq = q62_mul(rad, rad);
      term   = rad;
      acc    = rad;
      for (int n = 1; n <= 16; n++) begin
         term = q62_mul(term, rad_sq) / (64'(2 * n) * 64'(2 * n + 1));
         if (n % 2 == 1) begin
            acc = (term > acc) ? 64'd0 : acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc > UNIT_FIX) begin
         acc = UNIT_FIX;
      end
      mag = ((acc >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return mag[14:0];
   endfunction

   initial begin
      for (int k = 0; k <= QUARTER; k++) begin
         sine_lut[k] = quarter_sine(k);
      end
   end

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // rotated point for the current angle and pivot
   function automatic cloud_point_type rotate_about_pivot(input cloud_point_type p);
      cloud_point_type r;
      longint          sn;
      longint          cs;
      longint          dx;
      longint          dz;
      longint          px;
      longint          pz;
      int unsigned     a;
      a = turn_angle;
      if (a <= QUARTER) begin
         sn = sine_lut[a];
         cs = sine_lut[QUARTER - a];
      end else if (a <= 2 * QUARTER) begin
         sn = sine_lut[2 * QUARTER - a];
         cs = -longint'(sine_lut[a - QUARTER]);
      end else if (a <= 3 * QUARTER) begin
         sn = -longint'(sine_lut[a - 2 * QUARTER]);
         cs = -longint'(sine_lut[3 * QUARTER - a]);
      end else begin
         sn = -longint'(sine_lut[4 * QUARTER - a]);
         cs = sine_lut[a - 3 * QUARTER];
      end
      px  = longint'($signed(pivot_x_cfg));
      pz  = longint'($signed(pivot_z_cfg));
      dx  = longint'($signed(p.x)) - px;
      dz  = longint'($signed(p.z)) - pz;
      r   = p;
      r.x = clamp32(px + ((dx * cs - dz * sn) >>> 15));
      r.z = clamp32(pz + ((dx * sn + dz * cs) >>> 15));
      return r;
   endfunction

   function automatic cloud_point_type unpack_point(input logic [DATA_W-1:0] d,
                                                    input logic l);
      cloud_point_type p;
      p.x     = d[31:0];
      p.y     = d[63:32];
      p.z     = d[95:64];
      p.red   = d[103:96];
      p.green = d[111:104];
      p.blue  = d[119:112];
      p.last  = l;
      return p;
   endfunction

   // response checking, request prediction and register tracking
   always @(posedge clock) begin
      cloud_point_type got;
      cloud_point_type want;
      if (reset) begin
         turn_angle     <= 0;
         pivot_x_cfg    <= '0;
         pivot_y_cfg    <= '0;
         pivot_z_cfg    <= '0;
         angle_step_cfg <= '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_point(rsp_tdata, rsp_tlast);
            if (rotated_q.size() == 0) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("%0t: response with no request pending: %h", $realtime, got);
               end
               fail_count++;
            end else begin
               want = rotated_q.pop_front();
               if (got !== want) begin
                  if (fail_count < MAX_REPORTS) begin
                     $display("%0t: mismatch x %h/%h y %h/%h z %h/%h", $realtime,
                              want.x, got.x, want.y, got.y, want.z, got.z);
                     $display("   rgb %h%h%h/%h%h%h last %b/%b (expected/actual)",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue, want.last, got.last);
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = unpack_point(req_tdata, req_tlast);
            if (row_fixed) begin
               want.x = row_fixed_x;
               want.z = row_fixed_z;
            end else begin
               want = rotate_about_pivot(want);
            end
            rotated_q.push_back(want);
            points_done++;
            if (req_tlast) begin
               turn_angle <= (turn_angle + angle_step_cfg % FULL_TURN) % FULL_TURN;
               clouds_done++;
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_PIVOT_X:    pivot_x_cfg    <= csr_wdata;
               CSR_PIVOT_Y:    pivot_y_cfg    <= csr_wdata;
               CSR_PIVOT_Z:    pivot_z_cfg    <= csr_wdata;
               CSR_ANGLE_STEP: angle_step_cfg <= csr_wdata[12:0];
               default: ;
            endcase
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response back-pressure in random bursts
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   // waits for the model queue to empty, after first letting a request taken at the last edge reach it
   task automatic wait_drained();
      @(posedge clock);
      while (rotated_q.size() != 0) @(posedge clock);
   endtask

   // leaves csr_we high so back-to-back writes need one assignment per edge
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] step_word);
      write_reg(CSR_PIVOT_X, px);
      write_reg(CSR_PIVOT_Y, py);
      write_reg(CSR_PIVOT_Z, pz);
      write_reg(CSR_ANGLE_STEP, step_word);
      csr_we <= 1'b0;
      phases++;
   endtask

   // present one request and hold it until it is taken
   task automatic offer_point(input cloud_point_type p, input logic fixed,
                              input logic [31:0] fx, input logic [31:0] fz);
      req_tvalid  <= 1'b1;
      req_tdata   <= {p.blue, p.green, p.red, p.z, p.y, p.x};
      req_tlast   <= p.last;
      row_fixed   <= fixed;
      row_fixed_x <= fx;
      row_fixed_z <= fz;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_pivot();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3: return 32'($urandom_range(0, 2097151)) - 32'h00100000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [12:0] pick_step();
      case ($urandom_range(0, 7))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd5759;
         3: return 13'd5760;
         4: return 13'd8191;
         5: return 13'($urandom_range(0, 8191));
         default: return 13'($urandom_range(0, 5759));
      endcase
   endfunction

   // coordinates lean on the extremes and on the neighbourhood of the pivot
   function automatic logic [31:0] pick_coord(input logic [31:0] centre);
      case ($urandom_range(0, 9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3, 4: return centre + 32'($urandom_range(0, 131071)) - 32'h00010000;
         default: return $urandom();
      endcase
   endfunction

   function automatic cloud_point_type random_point();
      cloud_point_type p;
      p.x     = pick_coord(pivot_x_cfg);
      p.y     = ($urandom_range(0, 15) == 0) ? 32'h80000000 : $urandom();
      p.z     = pick_coord(pivot_z_cfg);
      p.red   = 8'($urandom_range(0, 255));
      p.green = 8'($urandom_range(0, 255));
      p.blue  = 8'($urandom_range(0, 255));
      p.last  = 1'b0;
      return p;
   endfunction

   // stimulus
   initial begin
      cloud_point_type pt;
      int              cur_set;
      int              sent;
      int              goal;
      int              len;
      bit              noisy;
      logic [31:0]     junk;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      row_fixed   <= 1'b0;
      row_fixed_x <= '0;
      row_fixed_z <= '0;
      csr_we      <= 1'b0;
      csr_addr    <= CSR_PIVOT_X;
      csr_wdata   <= '0;
      calm        = 1'b0;
      fail_count  = 0;
      points_done = 0;
      clouds_done = 0;
      phases      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table, registers reloaded whenever the set changes
      cur_set = -1;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].cfg_set != cur_set) begin
            req_tvalid <= 1'b0;
            wait_drained();
            cur_set = directed_rows[i].cfg_set;
            load_config(cfg_table[cur_set].px, cfg_table[cur_set].py,
                        cfg_table[cur_set].pz, {19'd0, cfg_table[cur_set].step});
         end
         offer_point(directed_rows[i].pt, directed_rows[i].fixed,
                     directed_rows[i].want_x, directed_rows[i].want_z);
         sender_gap();
      end

      // random clouds, a fresh register setting per phase, no idling at the end
      sent = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         calm = (ph == RANDOM_PHASES - 1);
         junk = $urandom();
         load_config(pick_pivot(), pick_pivot(), pick_pivot(), {junk[18:0], pick_step()});
         goal = (ph + 1) * RANDOM_POINTS / RANDOM_PHASES;
         while (sent < goal) begin
            noisy = ($urandom_range(0, 9) == 0);
            len   = noisy ? 1 : $urandom_range(1, 16);
            for (int j = 0; j < len; j++) begin
               pt      = random_point();
               pt.last = noisy ? 1'($urandom_range(0, 1)) : (j == len - 1);
               offer_point(pt, 1'b0, 32'h0, 32'h0);
               sent++;
               sender_gap();
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("checked %0d points (%0d directed, %0d random) under %0d register settings",
               points_done, NUM_DIRECTED, sent, phases);
      $display("%0d clouds closed, %0d failures", clouds_done, fail_count);
      if (fail_count == 0 && rotated_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
design/prot_pkg.sv
design/prot_sine_rom.sv
design/prot_front.sv
design/prot_queue.sv
design/prot_back.sv
design/point_rotate_about_y_pivot.sv
dv/tb_point_rotate_about_y_pivot.sv
